// File: rtl/core/dttfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal text to fixed point: shared package
// Phase codes, character codes, the flag group that travels with a finished
// number to the result register, and the power-of-ten helper.
// ----------------------------------------------------------------------------
package dttfp_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int CHAR_WIDTH  = 8;
   localparam int DIGIT_WIDTH = 4;

   localparam logic [CHAR_WIDTH-1:0] CHAR_TAB   = 8'd9;
   localparam logic [CHAR_WIDTH-1:0] CHAR_CR    = 8'd13;
   localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE = 8'd32;
   localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS  = 8'd43;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'd45;
   localparam logic [CHAR_WIDTH-1:0] CHAR_DOT   = 8'd46;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 8'd57;

   typedef enum logic [2:0] {
      PH_SPACE,
      PH_SIGN,
      PH_INT,
      PH_FRAC,
      PH_DONE
   } parse_phase_type;

   typedef enum logic [1:0] {
      CK_RUN,
      CK_ONE,
      CK_FAIL
   } check_phase_type;

   typedef struct packed {
      logic valid;
      logic negative;
      logic rejected;
      logic overflow;
   } flags_type;

   function automatic longint unsigned pow10(input int unsigned n);
      longint unsigned p;
      p = 64'd1;
      for (int unsigned i = 0; i < n; i++) begin
         p = p * 64'd10;
      end
      return p;
   endfunction

endpackage

// File: rtl/core/dttfp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal text to fixed point: character parser
// Walks one character per word through whitespace, signs, integer and
// fraction digits, and hands a finished number to the result register on the
// end word.
// ----------------------------------------------------------------------------
module dttfp_parser #(
   parameter int INT_BITS    = 31,
   parameter int FRAC_BITS   = 32,
   parameter int FRAC_DIGITS = 10,
   parameter int GW          = 34
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [dttfp_pkg::CHAR_WIDTH-1:0]    char_code,
   input  logic                                end_mark,
   output dttfp_pkg::flags_type                entry_flags,
   output logic [INT_BITS-1:0]                 entry_int,
   output logic [FRAC_BITS-1:0]                entry_quo
);

   localparam int CW = $clog2(FRAC_DIGITS + 1);
   localparam int IW = (FRAC_DIGITS > 1) ? $clog2(FRAC_DIGITS) : 1;
   localparam int AW = INT_BITS + 4;

   dttfp_pkg::parse_phase_type phase_ff, phase_in, body_phase;
   dttfp_pkg::check_phase_type check_ff, check_in;
   logic                       negative_ff, negative_in;
   logic [INT_BITS-1:0]        int_ff, int_in;
   logic [FRAC_BITS-1:0]       quo_ff, quo_in, quo_step;
   logic [GW-1:0]              rem_ff, rem_in, rem_step;
   logic [CW-1:0]              count_ff, count_in;
   logic                       sat_ff, sat_in;

   logic                       is_ws, is_sign, is_digit, is_dot, skip;
   logic [dttfp_pkg::DIGIT_WIDTH-1:0] digit;
   logic [AW-1:0]              int_next;

   dttfp_frac_div #(
      .FRAC_BITS   (FRAC_BITS),
      .FRAC_DIGITS (FRAC_DIGITS),
      .GW          (GW),
      .IW          (IW)
   ) u_frac_div (
      .position    (count_ff[IW-1:0]),
      .digit       (digit),
      .quo_cur     (quo_ff),
      .rem_cur     (rem_ff),
      .quo_next    (quo_step),
      .rem_next    (rem_step)
   );

   assign is_ws    = (char_code >= dttfp_pkg::CHAR_TAB && char_code <= dttfp_pkg::CHAR_CR)
                     || char_code == dttfp_pkg::CHAR_SPACE;
   assign is_sign  = char_code == dttfp_pkg::CHAR_PLUS || char_code == dttfp_pkg::CHAR_MINUS;
   assign is_digit = char_code >= dttfp_pkg::CHAR_ZERO && char_code <= dttfp_pkg::CHAR_NINE;
   assign is_dot   = char_code == dttfp_pkg::CHAR_DOT;
   assign digit    = dttfp_pkg::DIGIT_WIDTH'(char_code - dttfp_pkg::CHAR_ZERO);

   assign skip = (phase_ff == dttfp_pkg::PH_SPACE && is_ws)
                 || ((phase_ff == dttfp_pkg::PH_SPACE || phase_ff == dttfp_pkg::PH_SIGN)
                     && is_sign);
   assign body_phase = (phase_ff == dttfp_pkg::PH_SPACE || phase_ff == dttfp_pkg::PH_SIGN)
                       ? dttfp_pkg::PH_INT : phase_ff;

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (end_mark) begin
            phase_in = dttfp_pkg::PH_SPACE;
         end else if (skip) begin
            phase_in = is_sign ? dttfp_pkg::PH_SIGN : dttfp_pkg::PH_SPACE;
         end else begin
            unique case (body_phase)
               dttfp_pkg::PH_INT: begin
                  if (is_digit) begin
                     phase_in = dttfp_pkg::PH_INT;
                  end else if (is_dot) begin
                     phase_in = dttfp_pkg::PH_FRAC;
                  end else begin
                     phase_in = dttfp_pkg::PH_DONE;
                  end
               end
               dttfp_pkg::PH_FRAC: begin
                  phase_in = is_digit ? dttfp_pkg::PH_FRAC : dttfp_pkg::PH_DONE;
               end
               default: phase_in = dttfp_pkg::PH_DONE;
            endcase
         end
      end
   end

   always_comb begin
      check_in = check_ff;
      if (accept) begin
         if (end_mark) begin
            check_in = dttfp_pkg::CK_RUN;
         end else if (!skip) begin
            unique case (check_ff)
               dttfp_pkg::CK_RUN: begin
                  check_in = (!is_digit && !is_dot) ? dttfp_pkg::CK_ONE : dttfp_pkg::CK_RUN;
               end
               default: check_in = dttfp_pkg::CK_FAIL;
            endcase
         end
      end
   end

   assign int_next = ({4'd0, int_ff} << 3) + ({4'd0, int_ff} << 1) + AW'(digit);

   always_comb begin
      negative_in = negative_ff;
      int_in      = int_ff;
      sat_in      = sat_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      count_in    = count_ff;
      if (accept) begin
         if (end_mark) begin
            negative_in = 1'b0;
            int_in      = '0;
            sat_in      = 1'b0;
            quo_in      = '0;
            rem_in      = '0;
            count_in    = '0;
         end else if (skip) begin
            if (char_code == dttfp_pkg::CHAR_MINUS) begin
               negative_in = 1'b1;
            end
         end else if (is_digit && body_phase == dttfp_pkg::PH_INT) begin
            if (sat_ff || int_next[AW-1:INT_BITS] != '0) begin
               int_in = '1;
               sat_in = 1'b1;
            end else begin
               int_in = int_next[INT_BITS-1:0];
            end
         end else if (is_digit && body_phase == dttfp_pkg::PH_FRAC
                      && count_ff < CW'(FRAC_DIGITS)) begin
            quo_in   = quo_step;
            rem_in   = rem_step;
            count_in = count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= dttfp_pkg::PH_SPACE;
         check_ff    <= dttfp_pkg::CK_RUN;
         negative_ff <= 1'b0;
         int_ff      <= '0;
         sat_ff      <= 1'b0;
         quo_ff      <= '0;
         rem_ff      <= '0;
         count_ff    <= '0;
      end else begin
         phase_ff    <= phase_in;
         check_ff    <= check_in;
         negative_ff <= negative_in;
         int_ff      <= int_in;
         sat_ff      <= sat_in;
         quo_ff      <= quo_in;
         rem_ff      <= rem_in;
         count_ff    <= count_in;
      end
   end

   always_comb begin
      entry_flags.valid    = accept && end_mark;
      entry_flags.negative = negative_ff;
      entry_flags.rejected = check_ff == dttfp_pkg::CK_FAIL;
      entry_flags.overflow = check_ff != dttfp_pkg::CK_FAIL && sat_ff;
      entry_int = (check_ff == dttfp_pkg::CK_FAIL) ? '0 : int_ff;
      entry_quo = (check_ff == dttfp_pkg::CK_FAIL) ? '0 : quo_ff;
   end

endmodule

// File: rtl/core/dttfp_frac_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal text to fixed point: fraction step
// Adds one fraction digit to the binary fraction, kept as a quotient and a
// remainder against the fixed power of ten, from constant per-digit tables.
// ----------------------------------------------------------------------------
module dttfp_frac_div #(
   parameter int FRAC_BITS   = 32,
   parameter int FRAC_DIGITS = 10,
   parameter int GW          = 34,
   parameter int IW          = 4
) (
   input  logic [IW-1:0]                          position,
   input  logic [dttfp_pkg::DIGIT_WIDTH-1:0]      digit,
   input  logic [FRAC_BITS-1:0]                   quo_cur,
   input  logic [GW-1:0]                          rem_cur,
   output logic [FRAC_BITS-1:0]                   quo_next,
   output logic [GW-1:0]                          rem_next
);

   localparam int              NDIG    = 10;
   localparam logic [127:0]    DIV_VAL = 128'(dttfp_pkg::pow10(FRAC_DIGITS));
   localparam logic [GW:0]     DIVISOR = (GW + 1)'(DIV_VAL);

   logic [FRAC_BITS-1:0]  quo_tbl [FRAC_DIGITS][NDIG];
   logic [GW-1:0]         rem_tbl [FRAC_DIGITS][NDIG];
   logic [GW:0]           rem_sum;
   logic                  wrap;

   // A digit d at position k is worth d * 2^FRAC_BITS / 10^(k+1); each table
   // entry holds that amount as a whole part and a remainder over 10^FRAC_DIGITS.
   for (genvar k = 0; k < FRAC_DIGITS; k++) begin : g_pos
      for (genvar d = 0; d < NDIG; d++) begin : g_dig
         localparam logic [127:0] SCALED =
            (128'(d) * 128'(dttfp_pkg::pow10(FRAC_DIGITS - 1 - k))) << FRAC_BITS;
         assign quo_tbl[k][d] = FRAC_BITS'(SCALED / DIV_VAL);
         assign rem_tbl[k][d] = GW'(SCALED % DIV_VAL);
      end
   end

   assign rem_sum  = {1'b0, rem_cur} + {1'b0, rem_tbl[position][digit]};
   assign wrap     = rem_sum >= DIVISOR;
   assign rem_next = wrap ? GW'(rem_sum - DIVISOR) : GW'(rem_sum);
   assign quo_next = quo_cur + quo_tbl[position][digit] + FRAC_BITS'(wrap);

endmodule

// File: rtl/core/decimal_text_to_fixed_point.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal text to fixed point: top level
// The result word is registered: it appears in the cycle after the accepted end word.
// Throughput: one character word per cycle; each character updates the parse
// state in a single pass, so a new string may follow at once.
// A held result stalls the request side until it is taken.
// Synchronous reset clears the parse state and the result valid bit.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_point #(
   parameter int INT_BITS    = 31,
   parameter int FRAC_BITS   = 32,
   parameter int FRAC_DIGITS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [dttfp_pkg::CHAR_WIDTH-1:0]      req_char_code,
   input  logic                                  req_end_mark,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [dttfp_pkg::VALUE_WIDTH-1:0] rsp_fixed_value,
   output logic                                  rsp_rejected,
   output logic                                  rsp_int_overflow
);

   localparam int GW = $clog2(dttfp_pkg::pow10(FRAC_DIGITS));
   localparam int MW = INT_BITS + FRAC_BITS;
   localparam int VW = dttfp_pkg::VALUE_WIDTH;

   logic                  advance;
   logic                  accept;
   dttfp_pkg::flags_type  entry_flags;
   logic [INT_BITS-1:0]   entry_int;
   logic [FRAC_BITS-1:0]  entry_quo;
   logic [VW-1:0]         magnitude;

   logic                  valid_ff;
   logic [VW-1:0]         value_ff, value_in;
   logic                  rejected_ff, overflow_ff;

   assign advance   = !valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   dttfp_parser #(
      .INT_BITS    (INT_BITS),
      .FRAC_BITS   (FRAC_BITS),
      .FRAC_DIGITS (FRAC_DIGITS),
      .GW          (GW)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .char_code   (req_char_code),
      .end_mark    (req_end_mark),
      .entry_flags (entry_flags),
      .entry_int   (entry_int),
      .entry_quo   (entry_quo)
   );

   assign magnitude = {{(VW - MW){1'b0}}, entry_int, entry_quo};
   assign value_in  = entry_flags.negative ? (VW'(0) - magnitude) : magnitude;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= entry_flags.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         value_ff    <= value_in;
         rejected_ff <= entry_flags.rejected;
         overflow_ff <= entry_flags.overflow;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_fixed_value  = value_ff;
   assign rsp_rejected     = rejected_ff;
   assign rsp_int_overflow = overflow_ff;

endmodule

// File: rtl/core/dttfp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal text to fixed point: port checker
// Watches the top-level ports for result holding, back pressure, the
// rejected result form and the state after reset.
// ----------------------------------------------------------------------------
module dttfp_checker (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_stall,
   input  logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   input  logic signed [dttfp_pkg::VALUE_WIDTH-1:0] rsp_fixed_value,
   input  logic                                     rsp_rejected,
   input  logic                                     rsp_int_overflow
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_fixed_value)
         && $stable(rsp_rejected) && $stable(rsp_int_overflow))
      else $error("Held result word changed.");

   a_back_pressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("Request word taken while the result word is held.");

   a_reject_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_fixed_value == '0 && !rsp_int_overflow)
      else $error("Rejected result carries a value or an overflow flag.");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Result word valid right after reset.");

endmodule

bind decimal_text_to_fixed_point dttfp_checker u_dttfp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_fixed_value  (rsp_fixed_value),
   .rsp_rejected     (rsp_rejected),
   .rsp_int_overflow (rsp_int_overflow)
);
